FILE: rtl/sgf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int HALF_TAPS = 4;
  localparam int BACK_TAPS = 2 * HALF_TAPS;
  localparam int STRIDE_W  = 13;

  // Q0.18 weights; largest fits 17 bits unsigned
  localparam int WEIGHT_W = 17;
  localparam int FRAC_W   = 18;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int PROD_W   = PAIR_W + WEIGHT_W + 1;
  localparam int ACC_W    = PROD_W + 3;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_TAP_STRIDE = 1'b0;

  // center, then distance 1..4
  localparam logic [WEIGHT_W-1:0] PAIR_WEIGHT [HALF_TAPS+1] = '{
    17'd90137, 17'd62522, 17'd20197, 17'd3014, 17'd271
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    restart;
  } in_beat_t;

  typedef struct packed {
    sample_t filtered;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/sgf_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sgf_stream_if #(parameter type beat_t = logic);

  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: rtl/sgf_tap_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample history, replicated so all eight taps are read in the same cycle.
// Each bank: one write, two reads, read-first, registered read data.
module sgf_tap_store #(
  parameter int DEPTH = 32768
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [sgf_pkg::SAMPLE_W-1:0]  wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr [sgf_pkg::BACK_TAPS],
  output logic      [sgf_pkg::SAMPLE_W-1:0]  rd_data [sgf_pkg::BACK_TAPS]
);

  localparam int BANKS = sgf_pkg::BACK_TAPS / 2;

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    logic [sgf_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (en) begin
        mem[wr_addr]       <= wr_data;
        rd_data[2*g]       <= mem[rd_addr[2*g]];
        rd_data[2*g + 1]   <= mem[rd_addr[2*g + 1]];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/strided_nine_tap_gaussian_filter_top.sv
// Channel   Dir  Beat fields               Accepted when
// samples   in   sample[23:0] s, restart   samples.valid && samples.ready
// results   out  filtered[23:0] s          results.valid && results.ready
// apb       in   tap_stride @ 0x0          psel && penable && pwrite (pready=1)
//
// Sustained rate one beat per clock while results accepts; a beat that yields a
// result reaches results through the tap RAM read on the accept edge, then the
// weight, sum and round/sat (output register) stages.
// The rate is set by the tap RAM: four copies of the history, each with one
// write and two read ports, serve all eight back taps in the accept cycle.
// rst clears write pointer, fill count, stage valids; tap_stride resets to 1.
// The tap RAM is not cleared: the fill gate keeps unwritten entries unread.
// Under results back-pressure stages hold; samples.ready drops only once the
// three internal stages and the output register are all occupied.
`timescale 1ns / 1ps
`default_nettype none

module strided_nine_tap_gaussian_filter_top #(
  parameter int MAX_STRIDE = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  sgf_stream_if.sink                       samples,
  sgf_stream_if.source                     results,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sgf_pkg::APB_AW-1:0]  paddr,
  input  wire logic [sgf_pkg::APB_DW-1:0]  pwdata,
  output logic      [sgf_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int DEPTH  = sgf_pkg::BACK_TAPS * MAX_STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;   // holds DEPTH itself

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic signed [sgf_pkg::ACC_W-1:0] SAT_HI =
    sgf_pkg::ACC_W'((2 ** (sgf_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [sgf_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic signed [sgf_pkg::ACC_W-1:0] RND_HALF =
    sgf_pkg::ACC_W'(2 ** (sgf_pkg::FRAC_W - 1));

  // ---------------------------------------------------------------- config
  logic [sgf_pkg::STRIDE_W-1:0] tap_stride;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_stride <= sgf_pkg::STRIDE_W'(1);
    end else if (cfg_wr && paddr[2] == sgf_pkg::REG_TAP_STRIDE) begin
      tap_stride <= pwdata[sgf_pkg::STRIDE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == sgf_pkg::REG_TAP_STRIDE) begin
      prdata = sgf_pkg::APB_DW'(tap_stride);
    end else begin
      prdata = '0;
    end
  end

  // stride 0 acts as 1, above MAX_STRIDE it clamps to MAX_STRIDE
  logic [sgf_pkg::STRIDE_W-1:0] stride_eff;
  logic [CNT_W-1:0]             stride_cnt;
  logic [CNT_W-1:0]             span;

  always_comb begin
    if (tap_stride == '0) begin
      stride_eff = sgf_pkg::STRIDE_W'(1);
    end else if (32'(tap_stride) > 32'(MAX_STRIDE)) begin
      stride_eff = sgf_pkg::STRIDE_W'(MAX_STRIDE);
    end else begin
      stride_eff = tap_stride;
    end
  end

  assign stride_cnt = CNT_W'(stride_eff);
  assign span       = CNT_W'(stride_cnt * CNT_W'(sgf_pkg::BACK_TAPS));

  // ------------------------------------------------------- pipeline control
  // b: tap RAM read data, c: weighted pairs, d: sum, o: output register
  logic b_valid, c_valid, d_valid, o_valid;
  logic b_free, c_free, d_free, o_take;
  logic in_acc;

  assign o_take = !o_valid || results.ready;
  assign d_free = !d_valid || o_take;
  assign c_free = !c_valid || d_free;
  assign b_free = !b_valid || c_free;

  assign samples.ready = b_free;
  assign in_acc        = samples.valid && b_free;

  // ------------------------------------------------------ pointer and fill
  logic [ADDR_W-1:0] wp;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_base;
  logic              make;

  assign fill_base = samples.data.restart ? '0 : fill;
  assign make      = fill_base >= span;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (in_acc) begin
      wp   <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
      fill <= (fill_base < span) ? fill_base + 1'b1 : fill_base;
    end
  end

  // tap k+1 sits (k+1)*stride entries behind the write pointer
  logic [CNT_W-1:0]              tap_dist [sgf_pkg::BACK_TAPS];
  logic [CNT_W-1:0]              tap_idx  [sgf_pkg::BACK_TAPS];
  logic [CNT_W-1:0]              wp_cnt;
  logic [ADDR_W-1:0]             rd_addr  [sgf_pkg::BACK_TAPS];
  logic [sgf_pkg::SAMPLE_W-1:0]  rd_data  [sgf_pkg::BACK_TAPS];

  assign wp_cnt = CNT_W'(wp);

  always_comb begin
    for (int k = 0; k < sgf_pkg::BACK_TAPS; k++) begin
      tap_dist[k] = CNT_W'(CNT_W'(k + 1) * stride_cnt);
      tap_idx[k]  = (wp_cnt >= tap_dist[k]) ? wp_cnt - tap_dist[k]
                                             : wp_cnt + (DEPTH_CNT - tap_dist[k]);
      rd_addr[k]  = tap_idx[k][ADDR_W-1:0];
    end
  end

  // read-first: the furthest tap may share the write address this cycle
  sgf_tap_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .en      (in_acc),
    .wr_addr (wp),
    .wr_data (samples.data.sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ------------------------------------------------------------ datapath
  sgf_pkg::sample_t                    b_cur;
  sgf_pkg::sample_t                    taps     [sgf_pkg::BACK_TAPS+1];
  logic signed [sgf_pkg::PAIR_W-1:0]   pair     [sgf_pkg::HALF_TAPS+1];
  logic signed [sgf_pkg::PROD_W-1:0]   prod_next[sgf_pkg::HALF_TAPS+1];
  logic signed [sgf_pkg::PROD_W-1:0]   prod     [sgf_pkg::HALF_TAPS+1];
  logic signed [sgf_pkg::ACC_W-1:0]    acc_next;
  logic signed [sgf_pkg::ACC_W-1:0]    acc;
  logic signed [sgf_pkg::ACC_W-1:0]    rnd;
  logic signed [sgf_pkg::ACC_W-1:0]    shifted;
  sgf_pkg::sample_t                    filt_next;
  sgf_pkg::sample_t                    filt;

  // taps[0] is the current sample, taps[k] is k strides back
  always_comb begin
    taps[0] = b_cur;
    for (int k = 1; k <= sgf_pkg::BACK_TAPS; k++) begin
      taps[k] = $signed(rd_data[k-1]);
    end
  end

  // fold equal-distance pairs around the center, then weight
  always_comb begin
    pair[0] = sgf_pkg::PAIR_W'(taps[sgf_pkg::HALF_TAPS]);
    for (int j = 1; j <= sgf_pkg::HALF_TAPS; j++) begin
      pair[j] = sgf_pkg::PAIR_W'(taps[sgf_pkg::HALF_TAPS - j])
              + sgf_pkg::PAIR_W'(taps[sgf_pkg::HALF_TAPS + j]);
    end
    for (int j = 0; j <= sgf_pkg::HALF_TAPS; j++) begin
      prod_next[j] = pair[j] * $signed({1'b0, sgf_pkg::PAIR_WEIGHT[j]});
    end
  end

  always_comb begin
    acc_next = '0;
    for (int j = 0; j <= sgf_pkg::HALF_TAPS; j++) begin
      acc_next = acc_next + sgf_pkg::ACC_W'(prod[j]);
    end
  end

  // round half up, drop the fraction, clamp to the sample range
  always_comb begin
    rnd     = acc + RND_HALF;
    shifted = rnd >>> sgf_pkg::FRAC_W;
    if (shifted > SAT_HI) begin
      filt_next = SAT_HI[sgf_pkg::SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      filt_next = SAT_LO[sgf_pkg::SAMPLE_W-1:0];
    end else begin
      filt_next = shifted[sgf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid <= in_acc && make;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
      if (d_free) begin
        d_valid <= c_valid;
      end
      if (o_take) begin
        o_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_cur <= samples.data.sample;
    end
    if (c_free) begin
      prod <= prod_next;
    end
    if (d_free) begin
      acc <= acc_next;
    end
    if (o_take) begin
      filt <= filt_next;
    end
  end

  assign results.valid         = o_valid;
  assign results.data.filtered = filt;

  // ------------------------------------------------------------ checks
  a_restart_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc && samples.data.restart |=> fill == CNT_W'(1))
    else $error("fill count not restarted");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && wp != LAST_ADDR |=> wp == $past(wp) + 1'b1)
    else $error("write pointer did not advance");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(wp) && $stable(fill))
    else $error("pointer or fill moved without a beat");

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !c_free |=> b_valid && $stable(b_cur))
    else $error("read stage lost a stalled beat");

  a_d_hold: assert property (@(posedge clk) disable iff (rst)
    d_valid && !d_free |=> d_valid && $stable(acc))
    else $error("sum stage lost a stalled beat");

endmodule

`default_nettype wire
